### design/mard_pkg.sv
// Types and constants shared by the Modbus ASCII response deframer.
package mard_pkg;

    typedef struct packed {
        logic [7:0] rx_char;
        logic       read_failed;
    } t_req;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  byte_value;
        logic        reg_valid;
        logic [15:0] reg_value;
        logic        frame_end;
        logic [1:0]  status;
        logic [8:0]  frame_length;
        logic [7:0]  node_addr;
        logic [7:0]  function_code;
        logic [15:0] first_reg;
        logic [15:0] point_count;
        logic [7:0]  exc_code;
    } t_rsp;

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_ADDR   = 9'b000000010,
        PH_FUNC   = 9'b000000100,
        PH_EXC    = 9'b000001000,
        PH_COUNT  = 9'b000010000,
        PH_REGS   = 9'b000100000,
        PH_START  = 9'b001000000,
        PH_POINTS = 9'b010000000,
        PH_END    = 9'b100000000
    } t_phase;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_READ_FAIL = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [7:0] CHAR_COLON    = 8'h3A;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'h37; // 'A' - 10
    localparam logic [7:0] FUNC_EXC_BIT  = 8'h80;
    localparam logic [7:0] FUNC_READ_REG = 8'h03;
    localparam logic [7:0] FUNC_WRITE_MR = 8'h10;

    localparam logic [9:0]  MAX_LENGTH_RST = 10'd999;
    localparam logic [11:0] LENGTH_MARGIN  = 12'd6;

    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
        end else begin
            v = c - HEX_ALPHA_OFS;
        end
        return v;
    endfunction

endpackage

### design/modbus_ascii_response_deframer_unit.sv
// Modbus ASCII response deframer: per-character frame decode with registered result.
// One request (a character or a read-failure event) is taken per clock; the frame state
// and the result register update in the same cycle, so a result is shown the cycle after
// its request and a new request is taken every cycle while the result register is empty or
// being drained. Requests that yield no result (the start colon, the first character of a
// hex pair) just advance the state. max_length resets to 999. The user must write it through
// i_cfg_we/i_cfg_wdata only while no frame is in progress; the block does no check of this.
module modbus_ascii_response_deframer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mard_pkg::t_req    i_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mard_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_we,
    input  logic [9:0]        i_cfg_wdata
);
    import mard_pkg::*;

    logic [9:0]  r_max_length;
    t_phase      r_phase,      n_phase;
    logic [7:0]  r_first_char, n_first_char;
    logic [1:0]  r_char_slot,  n_char_slot;
    logic [6:0]  r_regs_left,  n_regs_left;
    logic [8:0]  r_count,      n_count;
    logic [7:0]  r_held_hi,    n_held_hi;
    logic [7:0]  r_addr,       n_addr;
    logic [7:0]  r_func,       n_func;
    logic [15:0] r_start,      n_start;
    logic [15:0] r_points,     n_points;
    logic [7:0]  r_bcount,     n_bcount;
    logic [7:0]  r_except,     n_except;
    logic        r_out_valid,  n_out_valid;
    t_rsp        r_rsp,        n_rsp;

    logic        w_accept;
    logic [7:0]  w_hi_nib;
    logic [7:0]  w_lo_nib;
    logic [7:0]  w_byte;
    logic [8:0]  w_count_inc;
    logic        w_too_long;
    logic [1:0]  w_status;
    logic        w_finish;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    assign w_hi_nib    = nibble_of(r_first_char);
    assign w_lo_nib    = nibble_of(i_req.rx_char);
    assign w_byte      = {w_hi_nib[3:0], 4'b0000} | w_lo_nib;
    assign w_count_inc = r_count + 9'd1;
    // signed compare of the new count against max_length - 6
    assign w_too_long  = $signed({3'b000, w_count_inc})
                         >= $signed({2'b00, r_max_length} - LENGTH_MARGIN);

    always_comb begin
        n_phase      = r_phase;
        n_first_char = r_first_char;
        n_char_slot  = r_char_slot;
        n_regs_left  = r_regs_left;
        n_count      = r_count;
        n_held_hi    = r_held_hi;
        n_addr       = r_addr;
        n_func       = r_func;
        n_start      = r_start;
        n_points     = r_points;
        n_bcount     = r_bcount;
        n_except     = r_except;
        n_rsp        = '0;
        w_finish     = 1'b0;
        w_status     = ST_OK;
        n_out_valid  = 1'b0;

        if (r_phase == PH_IDLE) begin
            n_char_slot = 2'd0;
            n_regs_left = '0;
            n_count     = '0;
            n_held_hi   = '0;
            n_addr      = '0;
            n_func      = '0;
            n_start     = '0;
            n_points    = '0;
            n_bcount    = '0;
            n_except    = '0;
            if (i_req.read_failed) begin
                w_finish = 1'b1;
                w_status = ST_READ_FAIL;
            end else if (i_req.rx_char != CHAR_COLON) begin
                w_finish = 1'b1;
                w_status = ST_BAD_START;
            end else begin
                n_phase = PH_ADDR;
            end
        end else if (i_req.read_failed) begin
            w_finish = 1'b1;
            w_status = ST_READ_FAIL;
        end else if (r_phase == PH_END) begin
            w_finish = 1'b1;
            w_status = ST_OK;
        end else if (!r_char_slot[0]) begin
            // hold the high character of the pair
            n_first_char = i_req.rx_char;
            n_char_slot  = r_char_slot + 2'd1;
        end else begin
            n_count          = w_count_inc;
            n_out_valid      = 1'b1;
            n_rsp.byte_valid = 1'b1;
            n_rsp.byte_value = w_byte;
            n_char_slot      = 2'd0;
            unique case (r_phase)
                PH_ADDR: begin
                    n_addr  = w_byte;
                    n_phase = PH_FUNC;
                end
                PH_FUNC: begin
                    n_func = w_byte;
                    priority if ((w_byte & FUNC_EXC_BIT) != 8'h00) begin
                        n_phase = PH_EXC;
                    end else if (w_byte == FUNC_READ_REG) begin
                        n_phase = PH_COUNT;
                    end else if (w_byte == FUNC_WRITE_MR) begin
                        n_phase = PH_START;
                    end else begin
                        n_phase = PH_END;
                    end
                end
                PH_EXC: begin
                    n_except = w_byte;
                    n_phase  = PH_END;
                end
                PH_COUNT: begin
                    n_bcount    = w_byte;
                    n_regs_left = w_byte[7:1];
                    n_phase     = (w_byte[7:1] != 7'd0) ? PH_REGS : PH_END;
                end
                PH_REGS: begin
                    if (r_char_slot == 2'd1) begin
                        n_held_hi   = w_byte;
                        n_char_slot = 2'd2;
                    end else begin
                        n_rsp.reg_valid = 1'b1;
                        n_rsp.reg_value = {r_held_hi, w_byte};
                        n_regs_left     = r_regs_left - 7'd1;
                        if (w_too_long) begin
                            w_finish = 1'b1;
                            w_status = ST_TOO_LONG;
                        end else if (n_regs_left == 7'd0) begin
                            n_phase = PH_END;
                        end
                    end
                end
                PH_START: begin
                    if (r_char_slot == 2'd1) begin
                        n_held_hi   = w_byte;
                        n_char_slot = 2'd2;
                    end else begin
                        n_start = {r_held_hi, w_byte};
                        n_phase = PH_POINTS;
                    end
                end
                PH_POINTS: begin
                    if (r_char_slot == 2'd1) begin
                        n_held_hi   = w_byte;
                        n_char_slot = 2'd2;
                    end else begin
                        n_points = {r_held_hi, w_byte};
                        n_phase  = PH_END;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (w_finish) begin
            n_out_valid         = 1'b1;
            n_rsp.frame_end     = 1'b1;
            n_rsp.status        = w_status;
            n_rsp.frame_length  = (w_status == ST_OK) ? n_count : 9'd0;
            n_rsp.node_addr     = n_addr;
            n_rsp.function_code = n_func;
            n_rsp.first_reg     = n_start;
            n_rsp.point_count   = n_points;
            n_rsp.exc_code      = n_except;
            n_phase             = PH_IDLE;
            n_char_slot         = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
            r_phase      <= PH_IDLE;
            r_first_char <= '0;
            r_char_slot  <= '0;
            r_regs_left  <= '0;
            r_count      <= '0;
            r_held_hi    <= '0;
            r_addr       <= '0;
            r_func       <= '0;
            r_start      <= '0;
            r_points     <= '0;
            r_bcount     <= '0;
            r_except     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_length <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_phase      <= n_phase;
                r_first_char <= n_first_char;
                r_char_slot  <= n_char_slot;
                r_regs_left  <= n_regs_left;
                r_count      <= n_count;
                r_held_hi    <= n_held_hi;
                r_addr       <= n_addr;
                r_func       <= n_func;
                r_start      <= n_start;
                r_points     <= n_points;
                r_bcount     <= n_bcount;
                r_except     <= n_except;
                r_out_valid  <= n_out_valid;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_out_valid) begin
            r_rsp <= n_rsp;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.read_failed) |=> (r_phase == PH_IDLE && r_char_slot == 2'd0))
        else $error("phase not idle after read failure");

    a_reg_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rsp.reg_valid) |-> o_rsp.byte_valid)
        else $error("register word without its low byte");

    a_summary_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rsp.frame_end)
            |-> (o_rsp.status == ST_OK && o_rsp.frame_length == 9'd0))
        else $error("summary fields set without frame end");

    a_length_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rsp.frame_length != 9'd0)
            |-> (o_rsp.frame_end && o_rsp.status == ST_OK))
        else $error("frame length on failed frame");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while result stalled");
`endif

endmodule

### verif/tb_top.sv
// Testbench for the Modbus ASCII response deframer: random frames checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import mard_pkg::*;

    typedef enum logic [1:0] {FK_OTHER, FK_EXC, FK_READ, FK_WRITE} t_kind;

    logic  i_clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    t_req  req = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_rsp  rsp;
    logic  cfg_we = 1'b0;
    logic  [9:0] cfg_wdata = '0;

    modbus_ascii_response_deframer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_req       (req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req char_q[$];
    t_rsp want_q[$];
    int   err_cnt = 0;
    int   acc_cnt = 0;
    int   snd_idle = 17;
    int   rcv_idle = 47;
    logic hold_rx = 1'b0;

    // predictor state
    t_phase      ph = PH_IDLE;
    logic [7:0]  hi_char = '0;
    logic [1:0]  slot = '0;
    logic [6:0]  left = '0;
    logic [8:0]  nbytes = '0;
    logic [7:0]  high_byte = '0;
    logic [7:0]  cap_addr = '0;
    logic [7:0]  cap_func = '0;
    logic [15:0] cap_start = '0;
    logic [15:0] cap_points = '0;
    logic [7:0]  cap_count = '0;
    logic [7:0]  cap_exc = '0;
    logic [9:0]  lim = MAX_LENGTH_RST;

    // unchecked hex digit value, wraps mod 256
    function automatic logic [7:0] nib(input logic [7:0] c);
        if (c <= "9") begin
            return c - "0";
        end
        return c - "A" + 8'd10;
    endfunction

    task automatic clear_capture();
        slot = '0;
        left = '0;
        nbytes = '0;
        high_byte = '0;
        cap_addr = '0;
        cap_func = '0;
        cap_start = '0;
        cap_points = '0;
        cap_count = '0;
        cap_exc = '0;
    endtask

    task automatic close_frame(inout t_rsp r, input logic [1:0] st);
        r.frame_end = 1'b1;
        r.status = st;
        r.frame_length = (st == ST_OK) ? nbytes : 9'd0;
        r.node_addr = cap_addr;
        r.function_code = cap_func;
        r.first_reg = cap_start;
        r.point_count = cap_points;
        r.exc_code = cap_exc;
        ph = PH_IDLE;
        slot = '0;
    endtask

    task automatic decode_char(input t_req rq);
        t_rsp r;
        logic [7:0] hv;
        logic [7:0] b;
        bit has;
        r = '0;
        has = 1'b0;
        if (ph == PH_IDLE) begin
            clear_capture();
            if (rq.read_failed) begin
                close_frame(r, ST_READ_FAIL);
                has = 1'b1;
            end else if (rq.rx_char != CHAR_COLON) begin
                close_frame(r, ST_BAD_START);
                has = 1'b1;
            end else begin
                ph = PH_ADDR;
            end
        end else if (rq.read_failed) begin
            close_frame(r, ST_READ_FAIL);
            has = 1'b1;
        end else if (ph == PH_END) begin
            close_frame(r, ST_OK);
            has = 1'b1;
        end else if (!slot[0]) begin
            hi_char = rq.rx_char;
            slot = slot + 2'd1;
        end else begin
            hv = nib(hi_char);
            b = {hv[3:0], 4'h0} | nib(rq.rx_char);
            nbytes = nbytes + 9'd1;
            r.byte_valid = 1'b1;
            r.byte_value = b;
            has = 1'b1;
            case (ph)
                PH_ADDR: begin
                    cap_addr = b;
                    slot = '0;
                    ph = PH_FUNC;
                end
                PH_FUNC: begin
                    cap_func = b;
                    slot = '0;
                    if ((b & FUNC_EXC_BIT) != 8'h00) ph = PH_EXC;
                    else if (b == FUNC_READ_REG) ph = PH_COUNT;
                    else if (b == FUNC_WRITE_MR) ph = PH_START;
                    else ph = PH_END;
                end
                PH_EXC: begin
                    cap_exc = b;
                    slot = '0;
                    ph = PH_END;
                end
                PH_COUNT: begin
                    cap_count = b;
                    slot = '0;
                    left = b[7:1];
                    ph = (left != 7'd0) ? PH_REGS : PH_END;
                end
                PH_REGS: begin
                    if (slot == 2'd1) begin
                        high_byte = b;
                        slot = 2'd2;
                    end else begin
                        r.reg_valid = 1'b1;
                        r.reg_value = {high_byte, b};
                        slot = '0;
                        left = left - 7'd1;
                        // signed compare: a limit below six is negative
                        if (int'(nbytes) >= int'(lim) - 6) close_frame(r, ST_TOO_LONG);
                        else if (left == 7'd0) ph = PH_END;
                    end
                end
                PH_START: begin
                    if (slot == 2'd1) begin
                        high_byte = b;
                        slot = 2'd2;
                    end else begin
                        cap_start = {high_byte, b};
                        slot = '0;
                        ph = PH_POINTS;
                    end
                end
                PH_POINTS: begin
                    if (slot == 2'd1) begin
                        high_byte = b;
                        slot = 2'd2;
                    end else begin
                        cap_points = {high_byte, b};
                        slot = '0;
                        ph = PH_END;
                    end
                end
                default: ;
            endcase
        end
        if (has) want_q.push_back(r);
    endtask

    function automatic string field_diff(input t_rsp e, input t_rsp g);
        string s;
        s = "";
        if (e.byte_valid !== g.byte_valid) s = {s, " byte_valid"};
        if (e.byte_value !== g.byte_value) s = {s, " byte_value"};
        if (e.reg_valid !== g.reg_valid) s = {s, " reg_valid"};
        if (e.reg_value !== g.reg_value) s = {s, " reg_value"};
        if (e.frame_end !== g.frame_end) s = {s, " frame_end"};
        if (e.status !== g.status) s = {s, " status"};
        if (e.frame_length !== g.frame_length) s = {s, " frame_length"};
        if (e.node_addr !== g.node_addr) s = {s, " node_addr"};
        if (e.function_code !== g.function_code) s = {s, " function_code"};
        if (e.first_reg !== g.first_reg) s = {s, " first_reg"};
        if (e.point_count !== g.point_count) s = {s, " point_count"};
        if (e.exc_code !== g.exc_code) s = {s, " exc_code"};
        return s;
    endfunction

    task automatic check_result(input t_rsp got);
        t_rsp e;
        string d;
        if (want_q.size() == 0) begin
            if (err_cnt < 10) $display("unexpected result %h", got);
            err_cnt++;
        end else begin
            e = want_q.pop_front();
            d = field_diff(e, got);
            if (d != "") begin
                if (err_cnt < 10) $display("mismatch in%s: exp %h got %h", d, e, got);
                err_cnt++;
            end
        end
    endtask

    // driver: offer the next request, predict on acceptance
    always @(posedge i_clk) begin
        bit take;
        take = in_valid && in_ready;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (take) begin
                decode_char(req);
                acc_cnt++;
            end
            if (!in_valid || take) begin
                if (char_q.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
                    req <= char_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) check_result(rsp);
        out_ready <= !hold_rx && ($urandom_range(0, 99) >= rcv_idle);
    end

    // long receiver hold-off mid-stream so the block backs up
    initial begin
        wait (acc_cnt >= 80);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic put(input logic [7:0] c, input logic f = 1'b0);
        t_req r;
        r.rx_char = c;
        r.read_failed = f;
        char_q.push_back(r);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'("0") + 8'(n) : 8'("A") + 8'(n) - 8'd10;
    endfunction

    // encode one byte, sometimes with non-hex characters that decode the same
    task automatic put_byte(input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] v;
        if ($urandom_range(0, 1)) begin
            put(hex_char(b[7:4]));
        end else begin
            do begin
                c = 8'($urandom_range(0, 255));
                v = nib(c);
            end while (v[3:0] != b[7:4] || c == CHAR_COLON);
            put(c);
        end
        if ($urandom_range(0, 1)) begin
            put(hex_char(b[3:0]));
        end else begin
            do c = 8'($urandom_range(0, 255));
            while (nib(c) != {4'h0, b[3:0]} || c == CHAR_COLON);
            put(c);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_frame(input t_kind k, input int force_cnt = -1);
        logic [7:0] f;
        logic [7:0] c;
        int n;
        put(CHAR_COLON);
        put_byte(pick_byte());
        case (k)
            FK_EXC: begin
                put_byte(FUNC_EXC_BIT | 8'($urandom_range(0, 127)));
                put_byte(pick_byte());
            end
            FK_READ: begin
                put_byte(FUNC_READ_REG);
                n = $urandom_range(0, 99);
                if (force_cnt >= 0) n = force_cnt;
                else if (n < 80) n = $urandom_range(0, 12);
                else if (n < 95) n = $urandom_range(13, 60);
                else n = $urandom_range(200, 255);
                put_byte(8'(n));
                repeat (n / 2) begin
                    put_byte(pick_byte());
                    put_byte(pick_byte());
                end
            end
            FK_WRITE: begin
                put_byte(FUNC_WRITE_MR);
                repeat (4) put_byte(pick_byte());
            end
            default: begin
                do f = 8'($urandom_range(0, 127));
                while (f == FUNC_READ_REG || f == FUNC_WRITE_MR);
                put_byte(f);
            end
        endcase
        do c = 8'($urandom_range(0, 255));
        while (c == CHAR_COLON);
        put(c);
    endtask

    task automatic fill_random(input int budget);
        int base;
        int start;
        int keep;
        int r;
        base = char_q.size();
        while (char_q.size() - base < budget) begin
            r = $urandom_range(0, 99);
            start = char_q.size();
            if (r < 72) begin
                put_frame(t_kind'($urandom_range(0, 3)));
            end else if (r < 84) begin
                // cut a frame short and fail the read
                put_frame(t_kind'($urandom_range(0, 3)));
                keep = $urandom_range(1, char_q.size() - start - 1);
                while (char_q.size() > start + keep) void'(char_q.pop_back());
                put(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                // raw noise, colons included, then a failed read to resync
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 3) == 0) put(CHAR_COLON);
                    else put(8'($urandom_range(0, 255)));
                end
                put(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        // leave the block idle
        put(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_idle();
        int n;
        while (char_q.size() != 0 || in_valid) @(posedge i_clk);
        n = 0;
        while (want_q.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        if (want_q.size() != 0) begin
            if (err_cnt < 10) $display("%0d results never arrived", want_q.size());
            err_cnt += want_q.size();
            want_q.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [9:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        lim = v;
    endtask

    initial begin
        logic [9:0] limits[8];
        limits = '{10'd999, 10'd1023, 10'd0, 10'd263, 10'd5, 10'd30, 10'd6, 10'd999};
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        put(8'h00, 1'b1);
        put(8'hFF);
        // address FF, function 0x10, read fails inside the start address
        put(CHAR_COLON); put("F"); put("F"); put("1"); put("0"); put(8'hA5, 1'b1);
        // exception response: address 00, function 80, code FF
        put(CHAR_COLON); put("0"); put("0"); put("8"); put("0"); put("F"); put("F"); put("Z");
        // read response with odd byte count 1: no registers
        put(CHAR_COLON); put("7"); put("F"); put("0"); put("3"); put("0"); put("1"); put(8'h00);

        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                wait_idle();
                set_limit(limits[p]);
            end
            snd_idle <= (p < 3) ? 17 : (p < 6) ? 47 : 0;
            rcv_idle <= (p < 3) ? 47 : (p < 6) ? 17 : 0;
            // longest register run lands exactly on the limit
            if (limits[p] == 10'd263) put_frame(FK_READ, 254);
            fill_random(60);
        end
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
